>>> rtl/core/csfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Cloth spring force evaluator: shared package
// Types, register indexes, request codes and fixed constants used by the
// evaluator core and its arithmetic units.
// ----------------------------------------------------------------------------
package csfe_pkg;

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_DATA_W = 216;
   localparam int RSP_DATA_W = 208;

   // Fixed arithmetic constants.
   localparam logic [19:0] GRAVITY_Q = 20'd642908;
   localparam logic [45:0] TERM_MAX  = {46{1'b1}};
   localparam logic [30:0] MASS_MIN  = 31'd65536;
   localparam logic [5:0]  SQRT_STEPS = 6'd32;
   localparam logic [5:0]  UDIV_STEPS = 6'd17;
   localparam logic [5:0]  ADIV_STEPS = 6'd32;
   localparam logic [5:0]  RCDIV_STEPS = 6'd10;
   localparam logic [3:0]  NB_LAST = 4'd11;

   // Register defaults.
   localparam logic [5:0]  SIDE_RST   = 6'd8;
   localparam logic [30:0] SPRING_RST = 31'd65536000;
   localparam logic [30:0] DRAG_RST   = 31'd655360;
   localparam logic [30:0] MASS_RST   = 31'd983040;
   localparam logic [30:0] REST_RST   = 31'd52429;
   localparam logic [30:0] SPACE_RST  = 31'd52429;

   typedef enum logic [2:0] {
      CSR_SIDE    = 3'd0,
      CSR_SPRING  = 3'd1,
      CSR_DRAG    = 3'd2,
      CSR_MASS    = 3'd3,
      CSR_REST    = 3'd4,
      CSR_SPACING = 3'd5,
      CSR_WIND    = 3'd6
   } csr_index_type;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_EVAL = 1'b1
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RD_SELF,
      ST_CAP_SELF,
      ST_DRAG,
      ST_GRAV,
      ST_SH_SQ,
      ST_SH_GO,
      ST_SH_WAIT,
      ST_RC_GO,
      ST_RC_WAIT,
      ST_NB_SEL,
      ST_NB_DIFF,
      ST_NB_SQ,
      ST_NB_RT_GO,
      ST_NB_RT_WAIT,
      ST_NB_ERR,
      ST_NB_T1,
      ST_NB_T2,
      ST_NB_U_GO,
      ST_NB_U_WAIT,
      ST_NB_MLO,
      ST_NB_MHI,
      ST_NB_ACC,
      ST_ACC_GO,
      ST_ACC_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        start;
      logic [63:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] root;
   } sqrt_rsp_type;

   typedef struct packed {
      logic        start;
      logic [31:0] divisor;
      logic [31:0] rem_init;
      logic [31:0] low_init;
      logic [5:0]  count;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quot;
      logic [31:0] rmd;
   } div_rsp_type;

   // Neighbor row and column offsets: structural, shear, then flex.
   function automatic logic signed [2:0] nb_dr(input logic [3:0] k);
      logic signed [2:0] r;
      case (k)
         4'd0, 4'd4, 4'd5: r = -3'sd1;
         4'd1, 4'd6, 4'd7: r = 3'sd1;
         4'd8:             r = -3'sd2;
         4'd9:             r = 3'sd2;
         default:          r = 3'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [2:0] nb_dc(input logic [3:0] k);
      logic signed [2:0] r;
      case (k)
         4'd2, 4'd4, 4'd6: r = -3'sd1;
         4'd3, 4'd5, 4'd7: r = 3'sd1;
         4'd10:            r = -3'sd2;
         4'd11:            r = 3'sd2;
         default:          r = 3'sd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/csfe_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module csfe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/core/csfe_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module csfe_sqrt (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire csfe_pkg::sqrt_req_type req,
   output csfe_pkg::sqrt_rsp_type      rsp
);
   import csfe_pkg::*;

   logic [63:0] rad_ff, rad_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [35:0] rem_sh;
   logic [35:0] trial;
   logic [35:0] rem_sub;

   // One restoring step: bring down two bits and try the next root bit.
   always_comb begin
      rem_sh  = {rem_ff, rad_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      rem_sub = rem_sh - trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rad_in  = req.radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = SQRT_STEPS;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[61:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sub[33:0];
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh[33:0];
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign rsp.done = done_ff;
   assign rsp.root = root_ff;

endmodule
`default_nettype wire

>>> rtl/core/csfe_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative restoring divider
// Shifts low dividend bits into a partial remainder, one quotient bit per
// cycle. The starting remainder must be below the divisor.
// ----------------------------------------------------------------------------
module csfe_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire csfe_pkg::div_req_type req,
   output csfe_pkg::div_rsp_type      rsp
);
   import csfe_pkg::*;

   logic [31:0] rem_ff, rem_in;
   logic [31:0] low_ff, low_in;
   logic [31:0] quot_ff, quot_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] rem_sh;
   logic [32:0] rem_sub;

   // Trial subtract of the divisor from the shifted remainder.
   always_comb begin
      rem_sh  = {rem_ff, low_ff[31]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.rem_init;
         low_in  = req.low_init;
         quot_in = '0;
         dvs_in  = req.divisor;
         cnt_in  = req.count;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         low_in = {low_ff[30:0], 1'b0};
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in  = rem_sub[31:0];
            quot_in = {quot_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh[31:0];
            quot_in = {quot_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rmd  = rem_ff;

endmodule
`default_nettype wire

>>> rtl/core/cloth_spring_force_eval_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Cloth spring force evaluator
// Usage: req_ carries words with tuser = command. A load word (command 0)
// writes one particle's position and velocity into the state RAMs in the
// cycle it is accepted and gives no response. An evaluate word (command 1)
// returns one rsp_ word with the particle's velocity and acceleration
// (gravity, drag, optional wind and up to 12 neighbor springs, over mass).
// Anchored corners answer without any spring work; indexes outside the grid
// give no response. A full evaluation visits each neighbor in the grid and
// ends with a divide by mass per component: each spring runs the shared
// square-root unit and three divides for its unit vector, and only one word
// is worked on at a time. req_tready is high
// only while idle. The result sits in an output register, so a new word is
// taken while it waits; a following evaluation holds in its last step until
// rsp_tready frees the register. Reset clears control state and restores
// register defaults; the RAM contents are undefined until loaded. csr_ writes
// are always accepted and must only occur while the block is idle.
// ----------------------------------------------------------------------------
module cloth_spring_force_eval_unit #(
   parameter int MAX_SIDE = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // tdata: particle_index, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
   //        wind_push, zero pad
   input  wire logic [csfe_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: cmd
   input  wire logic                            req_tuser,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // tdata: result_index, out_vel_x, out_vel_y, out_vel_z, acc_x, acc_y,
   //        acc_z, zero pad
   output logic      [csfe_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser: anchored, degenerate
   output logic      [1:0]                      rsp_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [2:0]                      csr_index,
   input  wire logic [31:0]                     csr_data
);
   import csfe_pkg::*;

   localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int LIN_W  = 2 * SIDE_W;
   localparam int RC_W   = SIDE_W + 2;
   localparam int F_W    = 56;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [5:0]  side_ff;
   logic [30:0] spring_ff, drag_ff, mass_ff, rest_ff, spacing_ff;
   logic        wind_en_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff    <= SIDE_RST;
         spring_ff  <= SPRING_RST;
         drag_ff    <= DRAG_RST;
         mass_ff    <= MASS_RST;
         rest_ff    <= REST_RST;
         spacing_ff <= SPACE_RST;
         wind_en_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_SIDE:    side_ff    <= csr_data[5:0];
            CSR_SPRING:  spring_ff  <= csr_data[30:0];
            CSR_DRAG:    drag_ff    <= csr_data[30:0];
            CSR_MASS:    mass_ff    <= csr_data[30:0];
            CSR_REST:    rest_ff    <= csr_data[30:0];
            CSR_SPACING: spacing_ff <= csr_data[30:0];
            CSR_WIND:    wind_en_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Clamped side and mass.
   logic [SIDE_W-1:0] side_c;
   logic [LIN_W-1:0]  side_sq;
   logic [30:0]       mass_c;

   always_comb begin
      if (side_ff < 6'd3) begin
         side_c = SIDE_W'(3);
      end else if (8'(side_ff) > 8'(MAX_SIDE)) begin
         side_c = SIDE_W'(MAX_SIDE);
      end else begin
         side_c = SIDE_W'(side_ff);
      end
      side_sq = LIN_W'(side_c) * LIN_W'(side_c);
      mass_c  = (mass_ff < MASS_MIN) ? MASS_MIN : mass_ff;
   end

   // ------------------------------------------------------------------
   // Request fields
   // ------------------------------------------------------------------
   logic [9:0]  req_idx;
   logic [95:0] req_pos, req_vel;
   logic [9:0]  req_wind;
   logic        req_acc;

   assign req_idx    = req_tdata[9:0];
   assign req_pos    = req_tdata[105:10];
   assign req_vel    = req_tdata[201:106];
   assign req_wind   = req_tdata[211:202];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   // ------------------------------------------------------------------
   // State RAMs: positions and velocities, x in the low word
   // ------------------------------------------------------------------
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic              pos_rd_en, vel_rd_en;
   logic [ADDR_W-1:0] pos_rd_addr;
   logic [95:0]       pos_rd_data, vel_rd_data;

   assign ram_wr_en   = req_acc && (cmd_type'(req_tuser) == CMD_LOAD) &&
                        (32'(req_idx) < 32'(DEPTH));
   assign ram_wr_addr = ADDR_W'(req_idx);

   csfe_ram #(.WIDTH(96), .DEPTH(DEPTH)) u_pos_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_pos),
      .rd_en   (pos_rd_en),
      .rd_addr (pos_rd_addr),
      .rd_data (pos_rd_data)
   );

   csfe_ram #(.WIDTH(96), .DEPTH(DEPTH)) u_vel_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_vel),
      .rd_en   (vel_rd_en),
      .rd_addr (pos_rd_addr),
      .rd_data (vel_rd_data)
   );

   // ------------------------------------------------------------------
   // Shared square root and divider
   // ------------------------------------------------------------------
   sqrt_req_type sqrt_req;
   sqrt_rsp_type sqrt_rsp;
   div_req_type  div_req;
   div_rsp_type  div_rsp;

   csfe_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req),
      .rsp   (sqrt_rsp)
   );

   csfe_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // ------------------------------------------------------------------
   // Sequencer and datapath registers
   // ------------------------------------------------------------------
   state_type state_ff, state_in;

   logic [9:0]          idx_ff, idx_in;
   logic [9:0]          wind_ff, wind_in;
   logic                anch_ff, anch_in;
   logic                flag_ff, flag_in;
   logic [1:0]          comp_ff, comp_in;
   logic [3:0]          nb_ff, nb_in;
   logic signed [31:0]  x_ff [3], x_in [3];
   logic signed [31:0]  v_ff [3], v_in [3];
   logic signed [F_W-1:0] f_ff [3], f_in [3];
   logic [31:0]         acc_ff [3], acc_in [3];
   logic [61:0]         gg_ff, gg_in;
   logic [31:0]         rest_sh_ff, rest_sh_in;
   logic [SIDE_W-1:0]   row_ff, row_in, col_ff, col_in;
   logic [30:0]         mag_ff [3], mag_in [3];
   logic                neg_ff [3], neg_in [3];
   logic [1:0]          shift_ff, shift_in;
   logic [63:0]         sum_ff, sum_in;
   logic [31:0]         lp_ff, lp_in;
   logic [34:0]         emag_ff, emag_in;
   logic                eneg_ff, eneg_in;
   logic [49:0]         t1_ff, t1_in;
   logic [45:0]         t_ff, t_in;
   logic [16:0]         u_ff, u_in;
   logic [39:0]         plo_ff, plo_in;
   logic [39:0]         phi_ff, phi_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [9:0]  rsp_idx_ff, rsp_idx_in;
   logic [31:0] rsp_vel_ff [3], rsp_vel_in [3];
   logic [31:0] rsp_acc_ff [3], rsp_acc_in [3];
   logic        rsp_anch_ff, rsp_anch_in;
   logic        rsp_degen_ff, rsp_degen_in;

   // Neighbor addressing.
   logic signed [2:0]      dr, dc;
   logic signed [RC_W-1:0] nb_r, nb_c;
   logic                   nb_ok;
   logic [LIN_W-1:0]       nb_lin;

   always_comb begin
      dr     = nb_dr(nb_ff);
      dc     = nb_dc(nb_ff);
      nb_r   = $signed({2'b00, row_ff}) + {{(RC_W-3){dr[2]}}, dr};
      nb_c   = $signed({2'b00, col_ff}) + {{(RC_W-3){dc[2]}}, dc};
      nb_ok  = (nb_r >= 0) && (nb_c >= 0) &&
               (nb_r < $signed({2'b00, side_c})) && (nb_c < $signed({2'b00, side_c}));
      nb_lin = LIN_W'(nb_r[SIDE_W-1:0]) * LIN_W'(side_c) + LIN_W'(nb_c[SIDE_W-1:0]);
   end

   // Temporaries of the datapath.
   logic [31:0]       vmag;
   logic [62:0]       drag_prod;
   logic [F_W-1:0]    drag_f;
   logic [F_W-1:0]    wind_f;
   logic [50:0]       grav_prod;
   logic signed [32:0] dvec [3];
   logic [32:0]       dmag [3];
   logic [32:0]       dmax;
   logic [1:0]        dshift;
   logic [33:0]       lp_sh;
   logic signed [35:0] err;
   logic [31:0]       rest_sel;
   logic [46:0]       t2_prod;
   logic [50:0]       t_sum;
   logic [62:0]       p_prod;
   logic [46:0]       p_val;
   logic [F_W-1:0]    fmag;
   logic              fneg;
   logic [32:0]       acc_lim;
   logic [32:0]       acc_a;
   logic [32:0]       acc_s;
   logic              spring_end;
   logic              acc_next;

   always_comb begin
      // Hold by default.
      state_in   = state_ff;
      idx_in     = idx_ff;
      wind_in    = wind_ff;
      anch_in    = anch_ff;
      flag_in    = flag_ff;
      comp_in    = comp_ff;
      nb_in      = nb_ff;
      x_in       = x_ff;
      v_in       = v_ff;
      f_in       = f_ff;
      acc_in     = acc_ff;
      gg_in      = gg_ff;
      rest_sh_in = rest_sh_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      shift_in   = shift_ff;
      sum_in     = sum_ff;
      lp_in      = lp_ff;
      emag_in    = emag_ff;
      eneg_in    = eneg_ff;
      t1_in      = t1_ff;
      t_in       = t_ff;
      u_in       = u_ff;
      plo_in     = plo_ff;
      phi_in     = phi_ff;

      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_vel_in   = rsp_vel_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_anch_in  = rsp_anch_ff;
      rsp_degen_in = rsp_degen_ff;

      pos_rd_en   = 1'b0;
      vel_rd_en   = 1'b0;
      pos_rd_addr = ADDR_W'(idx_ff);
      sqrt_req    = '0;
      div_req     = '0;
      spring_end  = 1'b0;
      acc_next    = 1'b0;

      // Drag, gravity and wind terms.
      vmag      = v_ff[comp_ff][31] ? 32'(-v_ff[comp_ff]) : 32'(v_ff[comp_ff]);
      drag_prod = 63'(drag_ff) * 63'(vmag);
      drag_f    = F_W'(drag_prod[62:16]);
      wind_f    = F_W'({req_wind_hold(wind_ff), 16'b0});
      grav_prod = 51'(mass_ff) * 51'(GRAVITY_Q);

      // Spring distance vector from the neighbor read.
      for (int c = 0; c < 3; c++) begin
         dvec[c] = $signed({x_ff[c][31], x_ff[c]}) -
                   $signed({pos_rd_data[32*c+31], pos_rd_data[32*c +: 32]});
         dmag[c] = dvec[c][32] ? 33'(-dvec[c]) : 33'(dvec[c]);
      end
      dmax = dmag[0] | dmag[1] | dmag[2];
      if (dmax[32]) begin
         dshift = 2'd2;
      end else if (dmax[31]) begin
         dshift = 2'd1;
      end else begin
         dshift = 2'd0;
      end

      // Spring extension and magnitude.
      if (nb_ff < 4'd4) begin
         rest_sel = {1'b0, rest_ff};
      end else if (nb_ff < 4'd8) begin
         rest_sel = rest_sh_ff;
      end else begin
         rest_sel = {spacing_ff, 1'b0};
      end
      lp_sh   = 34'(lp_ff) << shift_ff;
      err     = $signed({2'b00, lp_sh}) - $signed({4'b0000, rest_sel});
      t2_prod = 47'(spring_ff) * 47'(emag_ff[15:0]);
      t_sum   = 51'(t1_ff) + 51'(t2_prod[46:16]);
      p_prod  = (63'(phi_ff) << 23) + 63'(plo_ff);
      p_val   = p_prod[62:16];

      // Final divide by mass.
      fneg    = f_ff[comp_ff][F_W-1];
      fmag    = fneg ? F_W'(-f_ff[comp_ff]) : F_W'(f_ff[comp_ff]);
      acc_lim = fneg ? 33'h080000000 : 33'h07FFFFFFF;
      acc_a   = (33'(div_rsp.quot) > acc_lim) ? acc_lim : 33'(div_rsp.quot);
      acc_s   = fneg ? 33'(-acc_a) : acc_a;

      // Drain the output register.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (cmd_type'(req_tuser) == CMD_EVAL)) begin
               idx_in  = req_idx;
               wind_in = req_wind;
               anch_in = 1'b0;
               flag_in = 1'b0;
               if (16'(req_idx) < 16'(side_sq)) begin
                  if ((req_idx == 10'd0) || (req_idx == 10'(side_c - SIDE_W'(1)))) begin
                     anch_in  = 1'b1;
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_RD_SELF;
                  end
               end
            end
         end
         ST_RD_SELF: begin
            pos_rd_en = 1'b1;
            vel_rd_en = 1'b1;
            state_in  = ST_CAP_SELF;
         end
         ST_CAP_SELF: begin
            for (int c = 0; c < 3; c++) begin
               x_in[c] = pos_rd_data[32*c +: 32];
               v_in[c] = vel_rd_data[32*c +: 32];
            end
            comp_in  = 2'd0;
            state_in = ST_DRAG;
         end
         ST_DRAG: begin
            // Drag opposes velocity; wind pushes along x.
            f_in[comp_ff] = v_ff[comp_ff][31] ? $signed(drag_f) : -$signed(drag_f);
            if ((comp_ff == 2'd0) && wind_en_ff) begin
               f_in[comp_ff] = f_in[comp_ff] + $signed(wind_f);
            end
            if (comp_ff == 2'd2) begin
               state_in = ST_GRAV;
            end else begin
               comp_in = comp_ff + 2'd1;
            end
         end
         ST_GRAV: begin
            f_in[1]  = f_ff[1] - $signed(F_W'(grav_prod[50:16]));
            state_in = ST_SH_SQ;
         end
         ST_SH_SQ: begin
            gg_in    = 62'(spacing_ff) * 62'(spacing_ff);
            state_in = ST_SH_GO;
         end
         ST_SH_GO: begin
            sqrt_req.start    = 1'b1;
            sqrt_req.radicand = {1'b0, gg_ff, 1'b0};
            state_in          = ST_SH_WAIT;
         end
         ST_SH_WAIT: begin
            if (sqrt_rsp.done) begin
               rest_sh_in = sqrt_rsp.root;
               state_in   = ST_RC_GO;
            end
         end
         ST_RC_GO: begin
            // Row and column of the particle: index over side.
            div_req.start    = 1'b1;
            div_req.divisor  = 32'(side_c);
            div_req.rem_init = '0;
            div_req.low_init = {idx_ff, 22'b0};
            div_req.count    = RCDIV_STEPS;
            state_in         = ST_RC_WAIT;
         end
         ST_RC_WAIT: begin
            if (div_rsp.done) begin
               row_in   = SIDE_W'(div_rsp.quot);
               col_in   = SIDE_W'(div_rsp.rmd);
               nb_in    = 4'd0;
               state_in = ST_NB_SEL;
            end
         end
         ST_NB_SEL: begin
            if (nb_ok) begin
               pos_rd_en   = 1'b1;
               pos_rd_addr = ADDR_W'(nb_lin);
               state_in    = ST_NB_DIFF;
            end else begin
               spring_end = 1'b1;
            end
         end
         ST_NB_DIFF: begin
            for (int c = 0; c < 3; c++) begin
               mag_in[c] = 31'(dmag[c] >> dshift);
               neg_in[c] = dvec[c][32];
            end
            shift_in = dshift;
            sum_in   = '0;
            comp_in  = 2'd0;
            state_in = ST_NB_SQ;
         end
         ST_NB_SQ: begin
            sum_in = sum_ff + 64'(62'(mag_ff[comp_ff]) * 62'(mag_ff[comp_ff]));
            if (comp_ff == 2'd2) begin
               state_in = ST_NB_RT_GO;
            end else begin
               comp_in = comp_ff + 2'd1;
            end
         end
         ST_NB_RT_GO: begin
            sqrt_req.start    = 1'b1;
            sqrt_req.radicand = sum_ff;
            state_in          = ST_NB_RT_WAIT;
         end
         ST_NB_RT_WAIT: begin
            if (sqrt_rsp.done) begin
               lp_in = sqrt_rsp.root;
               if (sqrt_rsp.root == 32'd0) begin
                  // Zero-length spring: no force, flag it.
                  flag_in    = 1'b1;
                  spring_end = 1'b1;
               end else begin
                  state_in = ST_NB_ERR;
               end
            end
         end
         ST_NB_ERR: begin
            eneg_in  = err[35];
            emag_in  = err[35] ? 35'(-err) : 35'(err);
            state_in = ST_NB_T1;
         end
         ST_NB_T1: begin
            t1_in    = 50'(spring_ff) * 50'(emag_ff[34:16]);
            state_in = ST_NB_T2;
         end
         ST_NB_T2: begin
            if (t_sum > 51'(TERM_MAX)) begin
               t_in    = TERM_MAX;
               flag_in = 1'b1;
            end else begin
               t_in = t_sum[45:0];
            end
            comp_in  = 2'd0;
            state_in = ST_NB_U_GO;
         end
         ST_NB_U_GO: begin
            // Unit vector component: (mag << 16) / length.
            div_req.start    = 1'b1;
            div_req.divisor  = lp_ff;
            div_req.rem_init = {2'b00, mag_ff[comp_ff][30:1]};
            div_req.low_init = {mag_ff[comp_ff][0], 31'b0};
            div_req.count    = UDIV_STEPS;
            state_in         = ST_NB_U_WAIT;
         end
         ST_NB_U_WAIT: begin
            if (div_rsp.done) begin
               u_in     = div_rsp.quot[16:0];
               state_in = ST_NB_MLO;
            end
         end
         ST_NB_MLO: begin
            plo_in   = 40'(t_ff[22:0]) * 40'(u_ff);
            state_in = ST_NB_MHI;
         end
         ST_NB_MHI: begin
            phi_in   = 40'(t_ff[45:23]) * 40'(u_ff);
            state_in = ST_NB_ACC;
         end
         ST_NB_ACC: begin
            if (eneg_ff == neg_ff[comp_ff]) begin
               f_in[comp_ff] = f_ff[comp_ff] - $signed(F_W'(p_val));
            end else begin
               f_in[comp_ff] = f_ff[comp_ff] + $signed(F_W'(p_val));
            end
            if (comp_ff == 2'd2) begin
               spring_end = 1'b1;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = ST_NB_U_GO;
            end
         end
         ST_ACC_GO: begin
            if (fmag[F_W-1:16] >= (F_W-16)'(mass_c)) begin
               // Quotient reaches 2^32: saturate.
               acc_in[comp_ff] = fneg ? 32'h80000000 : 32'h7FFFFFFF;
               flag_in         = 1'b1;
               acc_next        = 1'b1;
            end else begin
               div_req.start    = 1'b1;
               div_req.divisor  = 32'(mass_c);
               div_req.rem_init = 32'(fmag[F_W-1:16]);
               div_req.low_init = {fmag[15:0], 16'b0};
               div_req.count    = ADIV_STEPS;
               state_in         = ST_ACC_WAIT;
            end
         end
         ST_ACC_WAIT: begin
            if (div_rsp.done) begin
               acc_in[comp_ff] = acc_s[31:0];
               if (33'(div_rsp.quot) > acc_lim) begin
                  flag_in = 1'b1;
               end
               acc_next = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = idx_ff;
               rsp_anch_in  = anch_ff;
               rsp_degen_in = anch_ff ? 1'b0 : flag_ff;
               for (int c = 0; c < 3; c++) begin
                  rsp_vel_in[c] = anch_ff ? 32'd0 : v_ff[c];
                  rsp_acc_in[c] = anch_ff ? 32'd0 : acc_ff[c];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Move to the next neighbor, or on to the mass divide.
      if (spring_end) begin
         if (nb_ff == NB_LAST) begin
            comp_in  = 2'd0;
            state_in = ST_ACC_GO;
         end else begin
            nb_in    = nb_ff + 4'd1;
            state_in = ST_NB_SEL;
         end
      end

      if (acc_next) begin
         if (comp_ff == 2'd2) begin
            state_in = ST_FINISH;
         end else begin
            comp_in  = comp_ff + 2'd1;
            state_in = ST_ACC_GO;
         end
      end
   end

   // Wind push value kept from the accepted word.
   function automatic logic [9:0] req_wind_hold(input logic [9:0] w);
      return w;
   endfunction

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      wind_ff      <= wind_in;
      anch_ff      <= anch_in;
      flag_ff      <= flag_in;
      comp_ff      <= comp_in;
      nb_ff        <= nb_in;
      x_ff         <= x_in;
      v_ff         <= v_in;
      f_ff         <= f_in;
      acc_ff       <= acc_in;
      gg_ff        <= gg_in;
      rest_sh_ff   <= rest_sh_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      shift_ff     <= shift_in;
      sum_ff       <= sum_in;
      lp_ff        <= lp_in;
      emag_ff      <= emag_in;
      eneg_ff      <= eneg_in;
      t1_ff        <= t1_in;
      t_ff         <= t_in;
      u_ff         <= u_in;
      plo_ff       <= plo_in;
      phi_ff       <= phi_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_vel_ff   <= rsp_vel_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_anch_ff  <= rsp_anch_in;
      rsp_degen_ff <= rsp_degen_in;
   end

   // Response word.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_degen_ff, rsp_anch_ff};
   assign rsp_tdata  = {6'b0, rsp_acc_ff[2], rsp_acc_ff[1], rsp_acc_ff[0],
                        rsp_vel_ff[2], rsp_vel_ff[1], rsp_vel_ff[0], rsp_idx_ff};

endmodule
`default_nettype wire
